### hdl/mif_pkg.sv
// ----------------------------------------------------------------------------
// mif_pkg
// shared types, codes and constant tables of the instrument fallback block
// ----------------------------------------------------------------------------
package mif_pkg;

    localparam int ChannelsDefault = 16;
    localparam int CfgIdxW = 8;

    typedef enum logic [2:0] {
        OP_PROG  = 3'd0,
        OP_CTRL  = 3'd1,
        OP_SYSEX = 3'd2,
        OP_RESET = 3'd3,
        OP_OTHER = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MSB  = 2'd1,
        KIND_LSB  = 2'd2,
        KIND_DRUM = 2'd3
    } t_kind;

    localparam logic [CfgIdxW-1:0] REG_ALLOW_SYSEX = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_ALT_PROG    = 8'd1;

    localparam logic [6:0] ALT_PROG_RESET = 7'd112;
    localparam logic [6:0] CC_BANK_MSB    = 7'd0;
    localparam logic [6:0] CC_BANK_LSB    = 7'd32;

    localparam logic [7:0] SX_MAKER  = 8'h41;
    localparam logic [7:0] SX_DEV    = 8'h10;
    localparam logic [7:0] SX_MODEL  = 8'h42;
    localparam logic [7:0] SX_CMD    = 8'h12;
    localparam logic [7:0] SX_ADDR_H = 8'h40;
    localparam logic [7:0] SX_ADDR_L = 8'h15;
    localparam logic [7:0] SX_END    = 8'hF7;
    localparam logic [7:0] SX_CH_LO  = 8'h10;
    localparam logic [7:0] SX_CH_SPL = 8'h1A;
    localparam logic [7:0] SX_CH_HI  = 8'h1F;
    localparam logic [3:0] SX_LEN    = 4'd10;
    localparam logic [3:0] SX_SAT    = 4'd11;
    localparam logic [3:0] DRUM_CH   = 4'd9;
    localparam logic [6:0] BANK_MAX  = 7'd63;

    typedef struct packed {
        logic [6:0] bank;
        logic [7:0] map;
        logic       ok;
    } t_chan;

    function automatic logic [6:0] drum_set_for(input logic [6:0] p);
        logic [6:0] r;
        if (p == 7'd25) begin
            r = 7'd25;
        end else if (p < 7'd64) begin
            r = p & 7'h38;
        end else if (p == 7'd127) begin
            r = 7'd127;
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

    function automatic logic var_bit(input logic [6:0] bank, input logic [6:0] p);
        logic r;
        r = 1'b0;
        case (bank)
            7'd0, 7'd127: r = 1'b1;
            7'd126: r = (p < 7'd64);
            7'd1: case (p) inside
                7'd38, 7'd57, 7'd60, 7'd80, 7'd81, 7'd98, 7'd102, 7'd104,
                [7'd120:7'd127]: r = 1'b1;
                default: r = 1'b0;
            endcase
            7'd2: case (p) inside
                7'd102, 7'd120, [7'd122:7'd127]: r = 1'b1;
                default: r = 1'b0;
            endcase
            7'd3: r = (p >= 7'd122);
            7'd4, 7'd5: case (p) inside
                7'd122, 7'd124, 7'd125, 7'd126: r = 1'b1;
                default: r = 1'b0;
            endcase
            7'd6, 7'd7: r = (p == 7'd125);
            7'd8: case (p) inside
                [7'd0:7'd6], 7'd11, 7'd12, 7'd14, 7'd16, 7'd17, 7'd19, 7'd21,
                [7'd24:7'd28], 7'd30, 7'd31, 7'd38, 7'd39, 7'd40, 7'd48, 7'd50,
                7'd61, 7'd62, 7'd63, 7'd80, 7'd81, 7'd107, [7'd115:7'd118],
                7'd125: r = 1'b1;
                default: r = 1'b0;
            endcase
            7'd9: case (p) inside
                7'd14, 7'd118, 7'd125: r = 1'b1;
                default: r = 1'b0;
            endcase
            7'd16: case (p) inside
                7'd0, 7'd4, 7'd5, 7'd6, 7'd16, 7'd19, 7'd24, 7'd25, 7'd28,
                7'd39, 7'd62, 7'd63: r = 1'b1;
                default: r = 1'b0;
            endcase
            7'd24: r = (p == 7'd4) || (p == 7'd6);
            7'd32: case (p) inside
                7'd16, 7'd17, 7'd24, 7'd52: r = 1'b1;
                default: r = 1'b0;
            endcase
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### hdl/mif_ifs.sv
// ----------------------------------------------------------------------------
// mif channel interfaces
// event input, fallback output and register write channels
// ----------------------------------------------------------------------------
interface mif_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [3:0] channel;
    logic [6:0] param_one;
    logic [6:0] param_two;
    logic [7:0] sysex_byte;
    logic       sysex_last;
    modport source (output valid, operation, channel, param_one, param_two,
                    sysex_byte, sysex_last, input ready);
    modport sink (input valid, operation, channel, param_one, param_two,
                  sysex_byte, sysex_last, output ready);
endinterface

interface mif_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] fallback_kind;
    logic [6:0] fallback_value;
    modport source (output valid, fallback_kind, fallback_value, input ready);
    modport sink (input valid, fallback_kind, fallback_value, output ready);
endinterface

interface mif_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/mif_chan_mem.sv
// ----------------------------------------------------------------------------
// mif_chan_mem
// per-channel state memory, registered read, valid bits give reset values
// ----------------------------------------------------------------------------
module mif_chan_mem
    import mif_pkg::*;
#(
    parameter int CHANNELS = ChannelsDefault,
    parameter int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_chan         o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_chan         i_wr_data
);
    t_chan         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    t_chan         r_q;
    logic          r_qv;
    logic [AW-1:0] r_qa;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q  <= r_mem[i_rd_addr];
            r_qa <= i_rd_addr;
            r_qv <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        if (r_qv) begin
            o_rd_data = r_q;
        end else begin
            o_rd_data.bank = 7'd0;
            o_rd_data.map  = (4'(r_qa) == DRUM_CH) ? 8'd1 : 8'd0;
            o_rd_data.ok   = 1'b0;
        end
    end
endmodule

### hdl/mif_var_rom.sv
// ----------------------------------------------------------------------------
// mif_var_rom
// bank variation bit table, 128 banks by 128 programs, registered read
// ----------------------------------------------------------------------------
module mif_var_rom
    import mif_pkg::*;
(
    input  logic       i_clk,
    input  logic [6:0] i_bank,
    input  logic [6:0] i_prog,
    output logic       o_bit
);
    logic r_bit;

    always_ff @(posedge i_clk) begin
        r_bit <= var_bit(i_bank, i_prog);
    end

    assign o_bit = r_bit;
endmodule

### hdl/midi_instrument_fallback_core.sv
// ----------------------------------------------------------------------------
// midi_instrument_fallback_core
// instrument fallback selector for a stream of midi events
// ----------------------------------------------------------------------------
// One event is taken at a time and answered with one fallback result. Sysex
// bytes, channel resets and ignored events go straight to the done state; a
// controller passes the channel state first; a program change may then also
// pass the table state and search bank variation rows one by one, as the
// channel state memory and the variation table have registered reads. A
// complete drum map message passes the check and write states on its last
// byte. The next event is taken once the result moves to the output register.
module midi_instrument_fallback_core
    import mif_pkg::*;
#(
    parameter int CHANNELS = ChannelsDefault
) (
    input logic      i_clk,
    input logic      i_rst_n,
    mif_in_if.sink   i_in,
    mif_out_if.source o_out,
    mif_cfg_if.sink  i_cfg
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHAN = 7'b0000010,
        S_TAB  = 7'b0000100,
        S_SRCH = 7'b0001000,
        S_SXCK = 7'b0010000,
        S_SXWR = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic       r_allow;
    logic [6:0] r_alt;
    logic [2:0] r_op;
    logic [3:0] r_ch;
    logic [6:0] r_p1, r_p2;
    logic [6:0] r_prog, n_prog;
    logic [6:0] r_v, n_v;
    t_chan      r_ent;
    logic [1:0] r_rk, n_rk;
    logic [6:0] r_rv, n_rv;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [6:0] r_val;
    logic [7:0] r_sx [10];
    logic [3:0] r_sx_cnt, n_sx_cnt;
    logic [AW-1:0] r_sxidx, n_sxidx;

    logic          accept;
    logic          mem_clr, mem_rd, mem_wr;
    logic [AW-1:0] mem_rd_addr, mem_wr_addr;
    t_chan         mem_q, mem_wd;
    logic [6:0]    rom_bank, rom_prog;
    logic          rom_bit;

    logic       is_prog;
    logic [6:0] prog, ds, vnext;
    logic [9:0] sx_sum;
    logic [7:0] sx_chk, sx_ch;
    logic [3:0] sx_idx;
    logic       sx_good;

    mif_chan_mem #(.CHANNELS(CHANNELS), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(mem_clr),
        .i_rd_en(mem_rd), .i_rd_addr(mem_rd_addr), .o_rd_data(mem_q),
        .i_wr_en(mem_wr), .i_wr_addr(mem_wr_addr), .i_wr_data(mem_wd)
    );

    mif_var_rom u_rom (
        .i_clk(i_clk), .i_bank(rom_bank), .i_prog(rom_prog), .o_bit(rom_bit)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.fallback_kind  = r_kind;
    assign o_out.fallback_value = r_val;

    assign n_sx_cnt = (r_sx_cnt < SX_SAT) ? r_sx_cnt + 4'd1 : r_sx_cnt;

    assign is_prog = (r_op == OP_PROG) || ((r_p1 != CC_BANK_MSB) &&
                     (r_p1 != CC_BANK_LSB) && (r_p1 == r_alt));
    assign prog  = (r_op == OP_PROG) ? r_p1 : r_p2;
    assign ds    = drum_set_for(prog);
    assign vnext = r_v - 7'd8;

    assign sx_sum = 10'(r_sx[4]) + 10'(r_sx[5]) + 10'(r_sx[6]) + 10'(r_sx[7]);
    assign sx_chk = 8'd128 - {1'b0, sx_sum[6:0]};
    assign sx_ch  = r_sx[5];
    always_comb begin
        if (sx_ch == SX_CH_LO) begin
            sx_idx = DRUM_CH;
        end else if (sx_ch < SX_CH_SPL) begin
            sx_idx = sx_ch[3:0] - 4'd1;
        end else begin
            sx_idx = sx_ch[3:0];
        end
    end
    assign sx_good = (r_sx[0] == SX_MAKER) && (r_sx[1] == SX_DEV) &&
                     (r_sx[2] == SX_MODEL) && (r_sx[3] == SX_CMD) &&
                     (r_sx[4] == SX_ADDR_H) && (r_sx[6] == SX_ADDR_L) &&
                     (r_sx[9] == SX_END) && (r_sx[8] == sx_chk) &&
                     (sx_ch >= SX_CH_LO) && (sx_ch <= SX_CH_HI) &&
                     ({1'b0, sx_idx} < 5'(CHANNELS));

    always_comb begin
        n_state     = r_state;
        n_prog      = r_prog;
        n_v         = r_v;
        n_rk        = r_rk;
        n_rv        = r_rv;
        n_sxidx     = r_sxidx;
        mem_clr     = 1'b0;
        mem_rd      = 1'b0;
        mem_rd_addr = i_in.channel[AW-1:0];
        mem_wr      = 1'b0;
        mem_wr_addr = r_ch[AW-1:0];
        mem_wd      = mem_q;
        rom_bank    = mem_q.bank;
        rom_prog    = prog;
        unique case (r_state)
            S_IDLE: begin
                n_rk = KIND_NONE;
                n_rv = 7'd0;
                if (accept) begin
                    n_state = S_DONE;
                    case (i_in.operation)
                        OP_SYSEX: begin
                            if (i_in.sysex_last && (n_sx_cnt == SX_LEN) && r_allow) begin
                                n_state = S_SXCK;
                            end
                        end
                        OP_RESET: mem_clr = 1'b1;
                        OP_PROG, OP_CTRL: begin
                            if ({1'b0, i_in.channel} < 5'(CHANNELS)) begin
                                mem_rd  = 1'b1;
                                n_state = S_CHAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CHAN: begin
                n_state = S_DONE;
                n_prog  = prog;
                if ((r_op == OP_CTRL) && (r_p1 == CC_BANK_MSB)) begin
                    mem_wr      = 1'b1;
                    mem_wd.bank = r_p2;
                    mem_wd.ok   = 1'b0;
                end else if ((r_op == OP_CTRL) && (r_p1 == CC_BANK_LSB)) begin
                    mem_wr    = 1'b1;
                    mem_wd.ok = 1'b0;
                    if (r_p2 != 7'd0) begin
                        n_rk = KIND_LSB;
                    end
                end else if (is_prog) begin
                    if (mem_q.map != 8'd0) begin
                        if (prog != ds) begin
                            mem_wr    = 1'b1;
                            mem_wd.ok = 1'b1;
                            n_rk      = KIND_DRUM;
                            n_rv      = ds;
                        end
                    end else if (mem_q.bank == 7'd0) begin
                        mem_wr    = 1'b1;
                        mem_wd.ok = 1'b1;
                    end else begin
                        n_state = S_TAB;
                    end
                end
            end
            S_TAB: begin
                mem_wd    = r_ent;
                mem_wd.ok = 1'b1;
                rom_bank  = r_ent.bank & 7'h38;
                rom_prog  = r_prog;
                n_state   = S_DONE;
                if (rom_bit) begin
                    mem_wr = 1'b1;
                end else begin
                    n_rk = KIND_MSB;
                    if (r_ent.ok && (r_ent.bank <= BANK_MAX) &&
                        ((r_ent.bank & 7'h38) != 7'd0)) begin
                        n_v     = r_ent.bank & 7'h38;
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                rom_bank = vnext;
                rom_prog = r_prog;
                if (rom_bit) begin
                    n_rv    = r_v;
                    n_state = S_DONE;
                end else if (vnext == 7'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_v = vnext;
                end
            end
            S_SXCK: begin
                mem_rd_addr = sx_idx[AW-1:0];
                n_sxidx     = sx_idx[AW-1:0];
                if (sx_good) begin
                    mem_rd  = 1'b1;
                    n_state = S_SXWR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SXWR: begin
                mem_wr      = 1'b1;
                mem_wr_addr = r_sxidx;
                mem_wd.map  = r_sx[7];
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_allow     <= 1'b1;
            r_alt       <= ALT_PROG_RESET;
            r_sx_cnt    <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_ALLOW_SYSEX: r_allow <= i_cfg.data[0];
                    REG_ALT_PROG:    r_alt   <= i_cfg.data;
                    default: r_allow <= r_allow;
                endcase
            end
            if (accept && (i_in.operation == OP_SYSEX)) begin
                r_sx_cnt <= i_in.sysex_last ? 4'd0 : n_sx_cnt;
            end
            if ((r_state == S_DONE) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prog  <= n_prog;
        r_v     <= n_v;
        r_rk    <= n_rk;
        r_rv    <= n_rv;
        r_sxidx <= n_sxidx;
        if (r_state == S_CHAN) begin
            r_ent <= mem_q;
        end
        if (accept) begin
            r_op <= i_in.operation;
            r_ch <= i_in.channel;
            r_p1 <= i_in.param_one;
            r_p2 <= i_in.param_two;
            if ((i_in.operation == OP_SYSEX) && (r_sx_cnt < SX_LEN)) begin
                r_sx[r_sx_cnt] <= i_in.sysex_byte;
            end
        end
        if ((r_state == S_DONE) && (!r_out_valid || o_out.ready)) begin
            r_kind <= r_rk;
            r_val  <= r_rv;
        end
    end

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_NONE) |-> (r_val == 7'd0))
        else $error("fallback value nonzero with kind none");

    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sx_cnt <= SX_SAT)
        else $error("sysex count beyond saturation");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("second event taken while one is in work");

    a_search_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> ((r_v != 7'd0) && (r_v[2:0] == 3'd0)))
        else $error("variation search left its bank grid");
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the instrument fallback block against a cycle-free model of its
// channel state, variation table and drum map message parser, with random
// idling on the event and result channels and register writes while idle
// ----------------------------------------------------------------------------
module tb;
    import mif_pkg::*;

    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] value;
    } t_fb;

    logic i_clk;
    logic i_rst_n;

    mif_in_if  ev_if ();
    mif_out_if fb_if ();
    mif_cfg_if cfg_if ();

    midi_instrument_fallback_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (ev_if.sink),
        .o_out  (fb_if.source),
        .i_cfg  (cfg_if.sink)
    );

    // model state
    logic [6:0] m_bank [16];
    logic [7:0] m_map  [16];
    logic       m_ok   [16];
    logic       m_table [128][128];
    logic [7:0] m_sx   [10];
    logic [3:0] m_sx_cnt;
    logic       m_allow;
    logic [6:0] m_alt;

    t_fb fb_expected [$];
    int  n_errors;
    int  idle_cycles;
    bit  hold_out;
    int  hold_len;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        n_errors++;
    endtask

    task automatic set_row(input int b, input int lo, input int hi);
        for (int p = lo; p <= hi; p++) m_table[b][p] = 1'b1;
    endtask

    task automatic model_clear_channels();
        for (int c = 0; c < 16; c++) begin
            m_bank[c] = '0;
            m_map[c] = '0;
            m_ok[c] = 1'b0;
        end
        m_map[DRUM_CH] = 8'd1;
    endtask

    task automatic model_reset();
        int pl1 [] = '{38, 57, 60, 80, 81, 98, 102, 104};
        int pl8 [] = '{11, 12, 14, 16, 17, 19, 21, 30, 31, 38, 39, 40, 48, 50, 61,
                       62, 63, 80, 81, 107, 125};
        int pl16 [] = '{0, 4, 5, 6, 16, 19, 24, 25, 28, 39, 62, 63};
        for (int b = 0; b < 128; b++)
            for (int p = 0; p < 128; p++) m_table[b][p] = 1'b0;
        set_row(0, 0, 127);
        set_row(127, 0, 127);
        set_row(126, 0, 63);
        foreach (pl1[i]) m_table[1][pl1[i]] = 1'b1;
        set_row(1, 120, 127);
        m_table[2][102] = 1'b1;
        m_table[2][120] = 1'b1;
        set_row(2, 122, 127);
        set_row(3, 122, 127);
        for (int b = 4; b <= 5; b++) begin
            m_table[b][122] = 1'b1;
            set_row(b, 124, 126);
        end
        m_table[6][125] = 1'b1;
        m_table[7][125] = 1'b1;
        set_row(8, 0, 6);
        set_row(8, 24, 28);
        set_row(8, 115, 118);
        foreach (pl8[i]) m_table[8][pl8[i]] = 1'b1;
        m_table[9][14] = 1'b1;
        m_table[9][118] = 1'b1;
        m_table[9][125] = 1'b1;
        foreach (pl16[i]) m_table[16][pl16[i]] = 1'b1;
        m_table[24][4] = 1'b1;
        m_table[24][6] = 1'b1;
        m_table[32][16] = 1'b1;
        m_table[32][17] = 1'b1;
        m_table[32][24] = 1'b1;
        m_table[32][52] = 1'b1;
        model_clear_channels();
        m_sx_cnt = '0;
        m_allow = 1'b1;
        m_alt = ALT_PROG_RESET;
    endtask

    function automatic logic [6:0] drum_set_of(input logic [6:0] p);
        if (p == 7'd25) return 7'd25;
        if (p < 7'd64) return p & 7'h38;
        if (p == 7'd127) return 7'd127;
        return 7'd0;
    endfunction

    task automatic program_fallback(input int ch, input logic [6:0] prog, output t_fb r);
        logic [6:0] bank;
        int v;
        bank = m_bank[ch];
        r = '0;
        if (m_map[ch] == 8'd0) begin
            if (bank == 7'd0 || m_table[bank][prog]) begin
                m_ok[ch] = 1'b1;
            end else begin
                r.kind = KIND_MSB;
                if (m_ok[ch] && bank <= BANK_MAX) begin
                    v = (bank / 8) * 8;
                    while (v > 0 && !m_table[v][prog]) v -= 8;
                    r.value = v[6:0];
                end
            end
        end else if (prog != drum_set_of(prog)) begin
            r.kind = KIND_DRUM;
            r.value = drum_set_of(prog);
            m_ok[ch] = 1'b1;
        end
    endtask

    task automatic apply_drum_map();
        logic [7:0] chk;
        int ch, idx;
        if (m_sx[0] != SX_MAKER || m_sx[1] != SX_DEV || m_sx[2] != SX_MODEL ||
            m_sx[3] != SX_CMD || m_sx[4] != SX_ADDR_H || m_sx[6] != SX_ADDR_L ||
            m_sx[9] != SX_END) return;
        chk = 8'((128 - ((m_sx[4] + m_sx[5] + m_sx[6] + m_sx[7]) % 128)));
        if (m_sx[8] != chk) return;
        ch = m_sx[5];
        if (ch < SX_CH_LO || ch > SX_CH_HI) return;
        if (ch == SX_CH_LO) idx = 9;
        else if (ch < SX_CH_SPL) idx = (ch & 15) - 1;
        else idx = ch & 15;
        m_map[idx] = m_sx[7];
    endtask

    task automatic predict_event(input logic [2:0] op, input logic [3:0] ch,
                                 input logic [6:0] p1, input logic [6:0] p2,
                                 input logic [7:0] sb, input logic last);
        t_fb r;
        r = '0;
        if (op == OP_SYSEX) begin
            if (m_sx_cnt < SX_LEN) m_sx[m_sx_cnt] = sb;
            if (m_sx_cnt < SX_SAT) m_sx_cnt++;
            if (last) begin
                if (m_sx_cnt == SX_LEN && m_allow) apply_drum_map();
                m_sx_cnt = '0;
            end
        end else if (op == OP_RESET) begin
            model_clear_channels();
        end else if (op == OP_PROG) begin
            program_fallback(ch, p1, r);
        end else if (op == OP_CTRL) begin
            if (p1 == CC_BANK_MSB) begin
                m_bank[ch] = p2;
                m_ok[ch] = 1'b0;
            end else if (p1 == CC_BANK_LSB) begin
                m_ok[ch] = 1'b0;
                if (p2 > 0) r.kind = KIND_LSB;
            end else if (p1 == m_alt) begin
                program_fallback(ch, p2, r);
            end
        end
        fb_expected.push_back(r);
    endtask

    task automatic send_event(input logic [2:0] op, input logic [3:0] ch,
                              input logic [6:0] p1, input logic [6:0] p2,
                              input logic [7:0] sb, input logic last);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_if.valid <= 1'b1;
        ev_if.operation <= op;
        ev_if.channel <= ch;
        ev_if.param_one <= p1;
        ev_if.param_two <= p2;
        ev_if.sysex_byte <= sb;
        ev_if.sysex_last <= last;
        do @(posedge i_clk); while (!ev_if.ready);
        predict_event(op, ch, p1, p2, sb, last);
    endtask

    task automatic send_sysex(input logic [7:0] msg []);
        int n;
        n = msg.size();
        for (int i = 0; i < n; i++)
            send_event(OP_SYSEX, 4'($urandom), 7'($urandom), 7'($urandom), msg[i],
                       i == n - 1);
    endtask

    function automatic logic [7:0] drum_ch_byte(input int idx);
        if (idx == 9) return SX_CH_LO;
        if (idx < 9) return 8'(SX_CH_LO + idx + 1);
        return 8'(SX_CH_LO + idx);
    endfunction

    task automatic send_drum_map(input logic [7:0] chb, input logic [7:0] map,
                                 input int flaw);
        logic [7:0] msg [];
        msg = new[10];
        msg = '{SX_MAKER, SX_DEV, SX_MODEL, SX_CMD, SX_ADDR_H, chb, SX_ADDR_L, map,
                8'((128 - ((SX_ADDR_H + chb + SX_ADDR_L + map) % 128))), SX_END};
        case (flaw)
            1: msg[$urandom_range(0, 9)] ^= 8'(1 << $urandom_range(0, 7));
            2: msg = new[$urandom_range(1, 9)] (msg);
            3: begin
                msg = new[$urandom_range(11, 14)] (msg);
                for (int i = 10; i < msg.size(); i++) msg[i] = 8'($urandom);
            end
            default: ;
        endcase
        send_sysex(msg);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [6:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_ALLOW_SYSEX) m_allow = data[0];
        else if (idx == REG_ALT_PROG) m_alt = data;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        ev_if.valid <= 1'b0;
        while (fb_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_random_event();
        int sel;
        logic [6:0] p1;
        sel = $urandom_range(0, 99);
        p1 = 7'($urandom);
        if (sel < 30) begin
            send_event(OP_PROG, 4'($urandom), 7'($urandom), 7'($urandom), 8'($urandom),
                       1'($urandom));
        end else if (sel < 60) begin
            case ($urandom_range(0, 3))
                0: p1 = CC_BANK_MSB;
                1: p1 = CC_BANK_LSB;
                2: p1 = m_alt;
                default: ;
            endcase
            send_event(OP_CTRL, 4'($urandom), p1,
                       ($urandom_range(0, 1) ? 7'($urandom_range(0, 9) * 8) :
                        7'($urandom)), 8'($urandom), 1'($urandom));
        end else if (sel < 75) begin
            send_drum_map(($urandom_range(0, 4) == 0) ? 8'($urandom) :
                          drum_ch_byte($urandom_range(0, 15)),
                          ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                          8'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ?
                          $urandom_range(1, 3) : 0);
        end else if (sel < 80) begin
            send_event(OP_SYSEX, 4'($urandom), 7'($urandom), 7'($urandom), 8'($urandom),
                       1'($urandom));
        end else if (sel < 83) begin
            send_event(OP_RESET, 4'($urandom), 7'($urandom), 7'($urandom), 8'($urandom),
                       1'($urandom));
        end else begin
            send_event(3'($urandom_range(4, 7)), 4'($urandom), 7'($urandom),
                       7'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_directed();
        send_event(OP_PROG, 4'd0, 7'd0, 7'd0, 8'h00, 1'b0);
        send_event(OP_PROG, 4'd15, 7'd127, 7'd127, 8'hFF, 1'b1);
        send_event(OP_PROG, 4'd9, 7'd26, 7'd0, 8'h00, 1'b0);
        send_event(OP_PROG, 4'd9, 7'd25, 7'd0, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd1, CC_BANK_MSB, 7'd17, 8'h00, 1'b0);
        send_event(OP_PROG, 4'd1, 7'd0, 7'd0, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd1, CC_BANK_MSB, 7'd9, 8'h00, 1'b0);
        send_event(OP_PROG, 4'd1, 7'd14, 7'd0, 8'h00, 1'b0);
        send_event(OP_PROG, 4'd1, 7'd0, 7'd0, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd1, CC_BANK_MSB, 7'd127, 8'h00, 1'b0);
        send_event(OP_PROG, 4'd1, 7'd5, 7'd0, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd2, CC_BANK_LSB, 7'd1, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd2, CC_BANK_LSB, 7'd0, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd2, ALT_PROG_RESET, 7'd64, 8'h00, 1'b0);
        send_drum_map(drum_ch_byte(3), 8'd1, 0);
        send_event(OP_PROG, 4'd3, 7'd30, 7'd0, 8'h00, 1'b0);
        send_drum_map(8'h0F, 8'd1, 0);
        send_drum_map(drum_ch_byte(12), 8'd1, 3);
        send_event(OP_RESET, 4'd0, 7'd0, 7'd0, 8'h00, 1'b0);
        send_event(OP_OTHER, 4'd0, 7'd0, 7'd0, 8'h00, 1'b0);
        send_event(3'd7, 4'd15, 7'd127, 7'd127, 8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_config();
        write_reg(REG_ALLOW_SYSEX, 7'd0);
        write_reg(REG_ALT_PROG, CC_BANK_MSB);
        send_drum_map(drum_ch_byte(4), 8'd1, 0);
        send_event(OP_PROG, 4'd4, 7'd30, 7'd0, 8'h00, 1'b0);
        send_event(OP_CTRL, 4'd4, CC_BANK_MSB, 7'd3, 8'h00, 1'b0);
        wait_drained();
        write_reg(REG_ALT_PROG, 7'd127);
        send_event(OP_CTRL, 4'd4, 7'd127, 7'd5, 8'h00, 1'b0);
        wait_drained();
        write_reg(REG_ALLOW_SYSEX, 7'd1);
        write_reg(REG_ALT_PROG, ALT_PROG_RESET);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_random_event();
        wait_drained();
        write_reg(REG_ALT_PROG, 7'($urandom));
        write_reg(REG_ALLOW_SYSEX, 7'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) send_random_event();
        wait_drained();
        write_reg(REG_ALLOW_SYSEX, 7'd1);
    endtask

    task automatic test_backpressure();
        hold_len = 300;
        hold_out = 1'b1;
        for (int i = 0; i < 30; i++) send_random_event();
        wait_drained();
    endtask

    // result side
    initial begin
        fb_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_out) begin
                fb_if.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_out = 1'b0;
            end
            fb_if.ready <= ($urandom_range(0, 2) != 0);
            @(posedge i_clk);
            if (fb_if.valid && fb_if.ready) begin
                if (fb_expected.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    t_fb e;
                    e = fb_expected.pop_front();
                    if (fb_if.fallback_kind !== e.kind)
                        report($sformatf("kind %0d want %0d", fb_if.fallback_kind, e.kind));
                    if (fb_if.fallback_value !== e.value)
                        report($sformatf("value %0d want %0d", fb_if.fallback_value,
                                         e.value));
                end
                if ($urandom_range(0, 3) == 0) begin
                    fb_if.ready <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((ev_if.valid && ev_if.ready) || (fb_if.valid && fb_if.ready) ||
                (cfg_if.valid && cfg_if.ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        n_errors = 0;
        hold_out = 1'b0;
        hold_len = 0;
        i_rst_n = 1'b0;
        ev_if.valid = 1'b0;
        ev_if.operation = OP_OTHER;
        ev_if.channel = '0;
        ev_if.param_one = '0;
        ev_if.param_two = '0;
        ev_if.sysex_byte = '0;
        ev_if.sysex_last = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config();
        test_backpressure();
        test_random(160);
        wait_drained();
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
